// ===== src/incremental_palindrome_check_macros.svh =====
// Assertion macros for the RTL file that carries checks (ipc_update.sv).
`ifndef INCREMENTAL_PALINDROME_CHECK_MACROS_SVH
`define INCREMENTAL_PALINDROME_CHECK_MACROS_SVH

`ifndef NO_ASSERTIONS

`define IPC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

`define IPC_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`else

`define IPC_ASSERT(label, prop)

`define IPC_ASSERT_NEVER(label, cond)

`endif

`endif

// ===== src/ipc_pkg.sv =====
package ipc_pkg;

  localparam int POS_W     = 10;
  localparam int CHAR_W    = 8;
  localparam int LEN_W     = 11;
  localparam int CNT_OUT_W = 10;
  localparam int LEN_RESET = 1024;

  typedef enum logic {
    IPC_CLEAR,
    IPC_RUN
  } ipc_state_e;

  typedef struct packed {
    logic                 all_match;
    logic [CNT_OUT_W-1:0] mismatched_pairs;
    logic                 position_error;
  } ipc_result_t;

endpackage

// ===== src/ipc_text_mem.sv =====
module ipc_text_mem
  import ipc_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [CHAR_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_a_i,
  input  logic [AW-1:0]     raddr_b_i,
  output logic [CHAR_W-1:0] rdata_a_o,
  output logic [CHAR_W-1:0] rdata_b_o
);

  logic [CHAR_W-1:0] mem_q [DEPTH];
  logic [CHAR_W-1:0] rdata_a_q;
  logic [CHAR_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== src/ipc_clear_seq.sv =====
module ipc_clear_seq
  import ipc_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output logic [AW-1:0] addr_o
);

  ipc_state_e    state_q, state_d;
  logic [AW-1:0] addr_q, addr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IPC_CLEAR;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
    end
  end

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    busy_o  = 1'b0;
    unique case (state_q)
      IPC_CLEAR: begin
        busy_o = 1'b1;
        if (start_i) begin
          addr_d = '0;
        end else if (addr_q == AW'(DEPTH - 1)) begin
          state_d = IPC_RUN;
          addr_d  = '0;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      IPC_RUN: begin
        if (start_i) begin
          state_d = IPC_CLEAR;
          addr_d  = '0;
        end
      end
      default: begin
        state_d = IPC_CLEAR;
        addr_d  = '0;
      end
    endcase
  end

  assign addr_o = addr_q;

endmodule

// ===== src/ipc_update.sv =====
`include "incremental_palindrome_check_macros.svh"

module ipc_update
  import ipc_pkg::*;
#(
  parameter int MAX_LENGTH = 1024,
  parameter int AW         = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              acc_i,
  input  logic [AW-1:0]     pos_addr_i,
  input  logic [AW-1:0]     mir_addr_i,
  input  logic [CHAR_W-1:0] char_i,
  input  logic              err_i,
  input  logic              mid_i,
  input  logic [CHAR_W-1:0] rd_pos_i,
  input  logic [CHAR_W-1:0] rd_mir_i,
  input  logic              out_stall_i,
  output logic              busy_o,
  output logic              we_o,
  output logic [AW-1:0]     waddr_o,
  output logic [CHAR_W-1:0] wdata_o,
  output logic              out_valid_o,
  output ipc_result_t       result_o
);

  localparam int CNT_W = $clog2(MAX_LENGTH / 2 + 1);

  logic              s1_valid_q;
  logic [AW-1:0]     s1_pos_q;
  logic [AW-1:0]     s1_mir_q;
  logic [CHAR_W-1:0] s1_char_q;
  logic              s1_err_q;
  logic              s1_mid_q;
  logic              fwd_valid_q;
  logic [AW-1:0]     fwd_addr_q;
  logic [CHAR_W-1:0] fwd_data_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q;
  ipc_result_t       out_q, out_d;

  logic              out_free;
  logic              s1_adv;
  logic [CHAR_W-1:0] cur_pos;
  logic [CHAR_W-1:0] cur_mir;
  logic              old_match;
  logic              new_match;
  logic              pair_upd;
  logic [31:0]       count_ext;

  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_adv   = s1_valid_q && out_free;
  assign busy_o   = s1_valid_q && !out_free;

  // take the write that landed while this transaction's reads were issued
  assign cur_pos = (fwd_valid_q && fwd_addr_q == s1_pos_q) ? fwd_data_q : rd_pos_i;
  assign cur_mir = (fwd_valid_q && fwd_addr_q == s1_mir_q) ? fwd_data_q : rd_mir_i;

  assign old_match = (cur_pos == cur_mir);
  assign new_match = (s1_char_q == cur_mir);
  assign pair_upd  = !s1_err_q && !s1_mid_q;

  always_comb begin
    count_d = count_q;
    if (pair_upd && old_match && !new_match) begin
      count_d = count_q + CNT_W'(1);
    end else if (pair_upd && !old_match && new_match) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  assign count_ext = 32'(count_d);

  always_comb begin
    out_d.all_match        = (count_d == '0);
    out_d.mismatched_pairs = count_ext[CNT_OUT_W-1:0];
    out_d.position_error   = s1_err_q;
  end

  assign we_o    = s1_adv && !s1_err_q;
  assign waddr_o = s1_pos_q;
  assign wdata_o = s1_char_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc_i) begin
        s1_valid_q  <= 1'b1;
        fwd_valid_q <= we_o;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (clear_i) begin
        count_q <= '0;
      end else if (s1_adv) begin
        count_q <= count_d;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_pos_q   <= pos_addr_i;
      s1_mir_q   <= mir_addr_i;
      s1_char_q  <= char_i;
      s1_err_q   <= err_i;
      s1_mid_q   <= mid_i;
      fwd_addr_q <= s1_pos_q;
      fwd_data_q <= s1_char_q;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  `IPC_ASSERT(a_match_flag, out_valid_q |-> (out_q.all_match == (out_q.mismatched_pairs == '0)))
  `IPC_ASSERT(a_err_keeps_count, (s1_adv && s1_err_q && !clear_i) |=> $stable(count_q))
  `IPC_ASSERT(a_clear_zeroes_count, clear_i |=> (count_q == '0))
  `IPC_ASSERT_NEVER(a_cnt_range, count_q > CNT_W'(MAX_LENGTH / 2))

endmodule

// ===== src/incremental_palindrome_check.sv =====
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_stall_o    position_i, character_i
// output    out        out_valid_o / out_stall_i  all_match_o, mismatched_pairs_o,
//                                                 position_error_o
// config    in         cfg_we_i                   string_length_i
//
// One transaction per cycle unless input is stalled; an accepted transaction waits in the
// compare stage for the character memory read, then its result enters the output register.
// After reset and after every length write a clearing pass zeroes the memory, one entry
// per cycle; input is stalled for its duration. A stalled output holds the result and
// stalls input once the compare stage is full.
module incremental_palindrome_check
  import ipc_pkg::*;
#(
  parameter int MAX_LENGTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [LEN_W-1:0]     string_length_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [POS_W-1:0]     position_i,
  input  logic [CHAR_W-1:0]    character_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 all_match_o,
  output logic [CNT_OUT_W-1:0] mismatched_pairs_o,
  output logic                 position_error_o
);

  localparam int AW      = $clog2(MAX_LENGTH);
  localparam int NW_MIN  = $clog2(MAX_LENGTH + 1);
  localparam int NW      = (NW_MIN > LEN_W) ? NW_MIN : LEN_W;
  localparam int RESET_N = (LEN_RESET > MAX_LENGTH) ? MAX_LENGTH : LEN_RESET;

  logic [NW-1:0]     len_q, len_d;
  logic [NW-1:0]     len_ext;
  logic [NW-1:0]     pos_ext;
  logic [NW-1:0]     mirror;
  logic              pos_err;
  logic              pos_mid;
  logic              acc;

  logic              clr_busy;
  logic [AW-1:0]     clr_addr;
  logic              upd_busy;
  logic              upd_we;
  logic [AW-1:0]     upd_waddr;
  logic [CHAR_W-1:0] upd_wdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [CHAR_W-1:0] rd_pos;
  logic [CHAR_W-1:0] rd_mir;
  ipc_result_t       result;

  // clamp the written length into one to MAX_LENGTH
  always_comb begin
    len_ext = NW'(string_length_i);
    len_d   = len_ext;
    if (len_ext == '0) begin
      len_d = NW'(1);
    end else if (len_ext > NW'(MAX_LENGTH)) begin
      len_d = NW'(MAX_LENGTH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= NW'(RESET_N);
    end else if (cfg_we_i) begin
      len_q <= len_d;
    end
  end

  assign pos_ext    = NW'(position_i);
  assign pos_err    = (pos_ext >= len_q);
  assign mirror     = len_q - NW'(1) - pos_ext;
  assign pos_mid    = (mirror == pos_ext);
  assign in_stall_o = clr_busy || upd_busy;
  assign acc        = in_valid_i && !in_stall_o;

  ipc_clear_seq #(
    .DEPTH (MAX_LENGTH),
    .AW    (AW)
  ) u_clear (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_we_i),
    .busy_o  (clr_busy),
    .addr_o  (clr_addr)
  );

  assign mem_we    = clr_busy || upd_we;
  assign mem_waddr = clr_busy ? clr_addr : upd_waddr;
  assign mem_wdata = clr_busy ? '0 : upd_wdata;

  ipc_text_mem #(
    .DEPTH (MAX_LENGTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (acc),
    .raddr_a_i (pos_ext[AW-1:0]),
    .raddr_b_i (mirror[AW-1:0]),
    .rdata_a_o (rd_pos),
    .rdata_b_o (rd_mir)
  );

  ipc_update #(
    .MAX_LENGTH (MAX_LENGTH),
    .AW         (AW)
  ) u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (clr_busy),
    .acc_i       (acc),
    .pos_addr_i  (pos_ext[AW-1:0]),
    .mir_addr_i  (mirror[AW-1:0]),
    .char_i      (character_i),
    .err_i       (pos_err),
    .mid_i       (pos_mid),
    .rd_pos_i    (rd_pos),
    .rd_mir_i    (rd_mir),
    .out_stall_i (out_stall_i),
    .busy_o      (upd_busy),
    .we_o        (upd_we),
    .waddr_o     (upd_waddr),
    .wdata_o     (upd_wdata),
    .out_valid_o (out_valid_o),
    .result_o    (result)
  );

  assign all_match_o        = result.all_match;
  assign mismatched_pairs_o = result.mismatched_pairs;
  assign position_error_o   = result.position_error;

endmodule
